[hdl/mstb_pkg.sv]
`default_nettype none

package mstb_pkg;

  // Bank size and time base
  localparam int NUM_SLOTS = 16;
  localparam int TIME_BITS = 32;
  localparam int SIDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [SIDX_W-1:0]    sidx_t;

  localparam sidx_t SLOT_LAST = sidx_t'(NUM_SLOTS - 1);

  // Command codes
  localparam logic [2:0] CMD_LINK   = 3'd0;
  localparam logic [2:0] CMD_UNLINK = 3'd1;
  localparam logic [2:0] CMD_START  = 3'd2;
  localparam logic [2:0] CMD_STOP   = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;
  localparam logic [2:0] CMD_TICK   = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_REPLY   = 2'd0;
  localparam logic [1:0] KIND_FIRED   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // Reply status codes
  localparam logic [1:0] ST_OK             = 2'd0;
  localparam logic [1:0] ST_NOT_LINKED     = 2'd1;
  localparam logic [1:0] ST_ALREADY_LINKED = 2'd2;

  // Write request into the slot store
  typedef struct packed {
    logic  link_set;
    logic  link_clr;
    logic  run_set;
    logic  run_clr;
    logic  dl_we;
    sidx_t idx;
    time_t dl_data;
  } store_wr_t;

endpackage

`default_nettype wire

[hdl/mstb_alu.sv]
`default_nettype none

// Shared add/subtract unit: deadline sums, time increment, remaining wait
module mstb_alu (
  input  mstb_pkg::time_t a,
  input  mstb_pkg::time_t b,
  input  logic            sub,
  output mstb_pkg::time_t res,
  output logic            reached
);

  assign res = sub ? (a - b) : (a + b);

  // difference of zero or wrapped negative means the deadline has passed
  assign reached = (res == '0) || res[mstb_pkg::TIME_BITS-1];

endmodule

`default_nettype wire

[hdl/mstb_slot_store.sv]
`default_nettype none

// Per-slot flags in flops, deadlines in a small memory with registered read
module mstb_slot_store (
  input  logic                            clk,
  input  logic                            rst,
  input  mstb_pkg::store_wr_t             wr,
  input  mstb_pkg::sidx_t                 rd_idx,
  output logic [mstb_pkg::NUM_SLOTS-1:0]  linked,
  output logic [mstb_pkg::NUM_SLOTS-1:0]  running,
  output mstb_pkg::time_t                 rd_deadline
);

  mstb_pkg::time_t deadline [mstb_pkg::NUM_SLOTS];

  // flag updates, one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      linked  <= '0;
      running <= '0;
    end else begin
      for (int i = 0; i < mstb_pkg::NUM_SLOTS; i++) begin
        if (wr.idx == mstb_pkg::sidx_t'(i)) begin
          if (wr.link_set) begin
            linked[i]  <= 1'b1;
            running[i] <= 1'b0;
          end
          if (wr.link_clr) begin
            linked[i]  <= 1'b0;
            running[i] <= 1'b0;
          end
          if (wr.run_set) running[i] <= 1'b1;
          if (wr.run_clr) running[i] <= 1'b0;
        end
      end
    end
  end

  // deadline memory
  always_ff @(posedge clk) begin
    if (wr.dl_we) deadline[wr.idx] <= wr.dl_data;
    rd_deadline <= deadline[rd_idx];
  end

endmodule

`default_nettype wire

[hdl/multi_slot_oneshot_timer_bank_unit.sv]
// Commands (link, unlink, start, stop, query): the item is latched in IDLE, then EXEC
// registers the reply and returns to IDLE, where the next item is taken; a stalled output holds EXEC.
// Tick: TICK_INC advances time, then SCAN takes one slot per cycle, unless a fired result
// waits on a stalled output, through the shared subtractor and the deadline memory read port;
// SUMMARY then registers the summary and returns to IDLE, holding while the output is stalled.
// Reset (rst, synchronous): time 0, all slots unlinked and stopped, output empty.
`default_nettype none

module multi_slot_oneshot_timer_bank_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // cmd[2:0], slot[6:3], duration[37:7], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // slot_id[3:0], is_running[4], status[6:5],
                                 // next_wait[38:7], zero pad
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast
);

  localparam int SW = mstb_pkg::SIDX_W;
  localparam int TB = mstb_pkg::TIME_BITS;

  typedef enum logic [2:0] {IDLE, EXEC, TICK_INC, SCAN, SUMMARY} state_t;

  state_t state;

  // latched item
  logic [2:0]  cmd_q;
  logic [3:0]  slot_q;
  logic [30:0] dur_q;

  // tick bookkeeping
  mstb_pkg::time_t time_q;
  mstb_pkg::time_t best_q;
  mstb_pkg::sidx_t scan_idx;
  logic            any_q;
  logic            fired_q;

  // output register
  logic [1:0]  o_kind;
  logic [3:0]  o_slot;
  logic        o_run;
  logic [1:0]  o_status;
  logic [31:0] o_wait;
  logic        o_last;

  // store and alu wiring
  mstb_pkg::store_wr_t            wr;
  mstb_pkg::sidx_t                rd_idx;
  logic [mstb_pkg::NUM_SLOTS-1:0] linked;
  logic [mstb_pkg::NUM_SLOTS-1:0] running;
  mstb_pkg::time_t                rd_deadline;
  mstb_pkg::time_t                alu_a;
  mstb_pkg::time_t                alu_b;
  logic                           alu_sub;
  mstb_pkg::time_t                alu_res;
  logic                           alu_reached;

  logic            can_push;
  logic            push;
  logic [SW+3:0]   slot_ext;
  mstb_pkg::sidx_t cur_idx;
  logic            slot_ok;
  logic            lk;
  logic [63:0]     dur64;
  logic [63:0]     dur_lim;
  mstb_pkg::time_t dur_sat;
  logic            scan_active;
  logic            fire;
  logic            advance;
  logic [1:0]      rep_status;
  logic            rep_run;
  logic [63:0]     best64;
  logic [31:0]     sum_wait;

  mstb_slot_store u_store (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .rd_idx      (rd_idx),
    .linked      (linked),
    .running     (running),
    .rd_deadline (rd_deadline)
  );

  mstb_alu u_alu (
    .a       (alu_a),
    .b       (alu_b),
    .sub     (alu_sub),
    .res     (alu_res),
    .reached (alu_reached)
  );

  assign s_tready = (state == IDLE);
  assign can_push = !m_tvalid || m_tready;

  assign m_tdata = {1'b0, o_wait, o_status, o_run, o_slot};
  assign m_tuser = o_kind;
  assign m_tlast = o_last;

  // addressed slot decode
  assign slot_ext = {SW'(0), slot_q};
  assign cur_idx  = slot_ext[SW-1:0];
  assign slot_ok  = 7'(slot_q) < 7'(mstb_pkg::NUM_SLOTS);
  assign lk       = slot_ok && linked[cur_idx];

  // start duration clipped to half the time range
  assign dur64   = 64'(dur_q);
  assign dur_lim = (64'd1 << (TB - 1)) - 64'd1;
  assign dur_sat = TB'((dur64 > dur_lim) ? dur_lim : dur64);

  // scan step
  assign scan_active = linked[scan_idx] && running[scan_idx];
  assign fire        = scan_active && alu_reached;
  assign advance     = !fire || can_push;

  // a result enters the output register this cycle
  assign push = can_push && ((state == EXEC) || (state == SUMMARY) || (state == SCAN && fire));

  // summary value
  assign best64 = 64'(best_q);
  always_comb begin
    if (fired_q)                      sum_wait = 32'd0;
    else if (!any_q)                  sum_wait = 32'hFFFF_FFFF;
    else if (best64 > 64'h7FFF_FFFF)  sum_wait = 32'h7FFF_FFFF;
    else                              sum_wait = best64[31:0];
  end

  // alu operand select
  always_comb begin
    alu_a   = time_q;
    alu_b   = TB'(1);
    alu_sub = 1'b0;
    unique case (state)
      EXEC: alu_b = dur_sat;
      SCAN: begin
        alu_a   = rd_deadline;
        alu_b   = time_q;
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  // deadline read address: one ahead of the slot under test
  always_comb begin
    rd_idx = '0;
    if (state == SCAN) rd_idx = advance ? mstb_pkg::sidx_t'(scan_idx + 1'b1) : scan_idx;
  end

  // command reply fields
  always_comb begin
    rep_status = mstb_pkg::ST_OK;
    rep_run    = 1'b0;
    case (cmd_q)
      mstb_pkg::CMD_LINK: begin
        if (!slot_ok)  rep_status = mstb_pkg::ST_NOT_LINKED;
        else if (lk)   rep_status = mstb_pkg::ST_ALREADY_LINKED;
      end
      mstb_pkg::CMD_START, mstb_pkg::CMD_STOP: begin
        if (!lk) rep_status = mstb_pkg::ST_NOT_LINKED;
      end
      mstb_pkg::CMD_QUERY: begin
        if (!lk) rep_status = mstb_pkg::ST_NOT_LINKED;
        else     rep_run = running[cur_idx];
      end
      default: ;
    endcase
  end

  // store writes
  always_comb begin
    wr         = '0;
    wr.idx     = cur_idx;
    wr.dl_data = alu_res;
    if (state == EXEC && can_push) begin
      case (cmd_q)
        mstb_pkg::CMD_LINK:   wr.link_set = slot_ok && !lk;
        mstb_pkg::CMD_UNLINK: wr.link_clr = slot_ok;
        mstb_pkg::CMD_START: begin
          wr.dl_we   = lk;
          wr.run_set = lk;
        end
        mstb_pkg::CMD_STOP:   wr.run_clr = lk;
        default: ;
      endcase
    end else if (state == SCAN && fire && can_push) begin
      wr.idx     = scan_idx;
      wr.run_clr = 1'b1;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
      time_q   <= '0;
      scan_idx <= '0;
      any_q    <= 1'b0;
      fired_q  <= 1'b0;
    end else begin
      if (push)          m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            cmd_q  <= s_tdata[2:0];
            slot_q <= s_tdata[6:3];
            dur_q  <= s_tdata[37:7];
            state  <= (s_tdata[2:0] == mstb_pkg::CMD_TICK) ? TICK_INC : EXEC;
          end
        end
        EXEC: begin
          if (can_push) begin
            o_kind   <= mstb_pkg::KIND_REPLY;
            o_slot   <= slot_q;
            o_run    <= rep_run;
            o_status <= rep_status;
            o_wait   <= 32'd0;
            o_last   <= 1'b1;
            state    <= IDLE;
          end
        end
        TICK_INC: begin
          time_q   <= alu_res;
          best_q   <= '0;
          scan_idx <= '0;
          any_q    <= 1'b0;
          fired_q  <= 1'b0;
          state    <= SCAN;
        end
        SCAN: begin
          if (fire) begin
            if (can_push) begin
              o_kind   <= mstb_pkg::KIND_FIRED;
              o_slot   <= 4'(scan_idx);
              o_run    <= 1'b0;
              o_status <= mstb_pkg::ST_OK;
              o_wait   <= 32'd0;
              o_last   <= 1'b0;
              fired_q  <= 1'b1;
            end
          end else if (scan_active && (!any_q || alu_res < best_q)) begin
            best_q <= alu_res;
            any_q  <= 1'b1;
          end
          if (advance) begin
            if (scan_idx == mstb_pkg::SLOT_LAST) state <= SUMMARY;
            else scan_idx <= mstb_pkg::sidx_t'(scan_idx + 1'b1);
          end
        end
        SUMMARY: begin
          if (can_push) begin
            o_kind   <= mstb_pkg::KIND_SUMMARY;
            o_slot   <= 4'd0;
            o_run    <= 1'b0;
            o_status <= mstb_pkg::ST_OK;
            o_wait   <= sum_wait;
            o_last   <= 1'b1;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/mstb_checker.sv]
`default_nettype none

module mstb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // output register comes up empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // accepted item leaves the block busy in the cycle after accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after accept");

  // a tick always ends with its summary
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == mstb_pkg::KIND_SUMMARY |-> m_tlast)
    else $error("summary without last");

  // a fired item is never the final one and carries no wait
  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == mstb_pkg::KIND_FIRED |-> !m_tlast && m_tdata[38:7] == 32'd0)
    else $error("fired item marked last or with a wait");

endmodule

bind multi_slot_oneshot_timer_bank_unit mstb_checker u_mstb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
